FILE: design/sfir_pkg.sv
// Shared types and constants for the symmetric FIR low-pass block.
// Used by sfir_line, sfir_mac and symmetric_fir_lowpass; depends on nothing.
`default_nettype none

package sfir_pkg;

  // Filter geometry
  localparam int TAPS     = 15;
  localparam int LINE_LEN = TAPS | 1;
  localparam int HALF     = (LINE_LEN - 1) / 2;
  localparam int NPAIR    = HALF + 1;
  localparam int CNT_W    = (NPAIR > 1) ? $clog2(NPAIR) : 1;

  // Coefficient register file
  localparam int NCOEF      = 8;
  localparam int COEF_IDX_W = 3;
  localparam int CFG_IDX_W  = 4;

  localparam int SAMPLE_W = 24;
  localparam int COEF_W   = 20;
  localparam int PAIR_W   = SAMPLE_W + 1;
  localparam int PROD_W   = PAIR_W + COEF_W;
  localparam int ACC_W    = 48;
  localparam int FRAC_W   = 16;
  localparam int Q_W      = ACC_W - FRAC_W;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [PAIR_W-1:0]   pair_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [ACC_W-1:0]    acc_t;
  typedef logic signed [Q_W-1:0]      q_t;

  localparam coef_t   COEF_CENTER_RST = 20'sd65536;
  localparam sample_t SAMPLE_MAX      = 24'sh7FFFFF;
  localparam sample_t SAMPLE_MIN      = 24'sh800000;
  localparam q_t      Q_MAX           = 32'sd8388607;
  localparam q_t      Q_MIN           = -32'sd8388608;

  // Control from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic clear;
    logic mul_en;
  } mac_ctl_t;

endpackage

`default_nettype wire

FILE: design/sfir_line.sv
// Sample delay line and symmetric pair adders.
// Depends on sfir_pkg.
`default_nettype none

module sfir_line (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             shift_en,
  input  wire sfir_pkg::sample_t sample_in,
  output sfir_pkg::pair_t       pairs [sfir_pkg::NPAIR]
);

  sfir_pkg::sample_t line [sfir_pkg::LINE_LEN];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < sfir_pkg::LINE_LEN; i++) begin
        line[i] <= '0;
      end
    end else if (shift_en) begin
      for (int i = 0; i < sfir_pkg::LINE_LEN - 1; i++) begin
        line[i] <= line[i + 1];
      end
      line[sfir_pkg::LINE_LEN - 1] <= sample_in;
    end
  end

  // pair 0 is the center tap alone, pair k folds the taps k away from center
  assign pairs[0] = sfir_pkg::pair_t'(line[sfir_pkg::HALF]);

  for (genvar k = 1; k < sfir_pkg::NPAIR; k++) begin : g_pair
    assign pairs[k] = sfir_pkg::pair_t'(line[sfir_pkg::HALF + k])
                    + sfir_pkg::pair_t'(line[sfir_pkg::HALF - k]);
  end

endmodule

`default_nettype wire

FILE: design/sfir_mac.sv
// Shared multiply-accumulate unit with truncate-toward-zero scaling and saturation.
// Depends on sfir_pkg.
`default_nettype none

module sfir_mac (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire sfir_pkg::mac_ctl_t  ctl,
  input  wire sfir_pkg::pair_t     pair_op,
  input  wire sfir_pkg::coef_t     coef_op,
  output sfir_pkg::sample_t        result
);

  sfir_pkg::prod_t prod;
  sfir_pkg::prod_t prod_next;
  logic            prod_vld;
  sfir_pkg::acc_t  acc;
  sfir_pkg::q_t    q;
  logic            round_up;

  assign prod_next = pair_op * coef_op;

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod <= prod_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= ctl.mul_en;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc <= '0;
    end else if (prod_vld) begin
      acc <= acc + sfir_pkg::acc_t'(prod);
    end
  end

  // arithmetic shift floors; bump negatives with a nonzero fraction toward zero
  assign round_up = acc[sfir_pkg::ACC_W-1] && (|acc[sfir_pkg::FRAC_W-1:0]);
  assign q = sfir_pkg::q_t'(acc[sfir_pkg::ACC_W-1:sfir_pkg::FRAC_W])
           + sfir_pkg::q_t'({1'b0, round_up});

  always_comb begin
    if (q > sfir_pkg::Q_MAX) begin
      result = sfir_pkg::SAMPLE_MAX;
    end else if (q < sfir_pkg::Q_MIN) begin
      result = sfir_pkg::SAMPLE_MIN;
    end else begin
      result = q[sfir_pkg::SAMPLE_W-1:0];
    end
  end

endmodule

`default_nettype wire

FILE: design/symmetric_fir_lowpass.sv
// An accepted word passes through the load, multiply, drain and done states to out_valid.
// The single shared 25x20 multiplier steps over the 8 folded coefficient pairs in the multiply
//   state; a new word is taken only once the previous one has left the done state.
//   in_stall is high while an item is in flight.
// A finished word waits in the output register while the next input is taken.
// Reset (rst, synchronous): delay line zeroed, coef_center = 1.0, other coefficients 0.
// Top level: sequencer, coefficient registers, pair shift register; uses sfir_line, sfir_mac.
`default_nettype none

module symmetric_fir_lowpass (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire sfir_pkg::sample_t                sample_in,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output sfir_pkg::sample_t                     sample_out,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [sfir_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire sfir_pkg::coef_t                  cfg_data
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_LOAD  = 3'd1;
  localparam logic [2:0] ST_MAC   = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]                  state;
  logic [2:0]                  state_next;
  logic [sfir_pkg::CNT_W-1:0]  cnt;
  sfir_pkg::coef_t             coef [sfir_pkg::NCOEF];
  sfir_pkg::pair_t             pairs [sfir_pkg::NPAIR];
  sfir_pkg::pair_t             pair_q [sfir_pkg::NPAIR];
  sfir_pkg::mac_ctl_t          mac_ctl;
  sfir_pkg::sample_t           mac_result;
  logic                        in_take;
  logic                        out_load;
  logic                        last_step;

  assign in_stall  = (state != ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign last_step = (cnt == sfir_pkg::CNT_W'(sfir_pkg::NPAIR - 1));
  assign out_load  = (state == ST_DONE) && (!out_valid || !out_stall);

  assign mac_ctl.clear  = (state == ST_LOAD);
  assign mac_ctl.mul_en = (state == ST_MAC);

  // Coefficient registers; indexes past the file are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      coef[0] <= sfir_pkg::COEF_CENTER_RST;
      for (int i = 1; i < sfir_pkg::NCOEF; i++) begin
        coef[i] <= '0;
      end
    end else if (cfg_valid && cfg_ready
                 && (cfg_index < sfir_pkg::CFG_IDX_W'(sfir_pkg::NCOEF))) begin
      coef[cfg_index[sfir_pkg::COEF_IDX_W-1:0]] <= cfg_data;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_take) state_next = ST_LOAD;
      ST_LOAD:  state_next = ST_MAC;
      ST_MAC:   if (last_step) state_next = ST_DRAIN;
      ST_DRAIN: state_next = ST_DONE;
      ST_DONE:  if (out_load) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == ST_LOAD) begin
        cnt <= '0;
      end else if (state == ST_MAC) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  // Folded pairs shift down one slot per multiply
  always_ff @(posedge clk) begin
    if (state == ST_LOAD) begin
      pair_q <= pairs;
    end else if (state == ST_MAC) begin
      for (int k = 0; k < sfir_pkg::NPAIR - 1; k++) begin
        pair_q[k] <= pair_q[k + 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      sample_out <= mac_result;
    end
  end

  sfir_line u_line (
    .clk       (clk),
    .rst       (rst),
    .shift_en  (in_take),
    .sample_in (sample_in),
    .pairs     (pairs)
  );

  sfir_mac u_mac (
    .clk     (clk),
    .rst     (rst),
    .ctl     (mac_ctl),
    .pair_op (pair_q[0]),
    .coef_op (coef[sfir_pkg::COEF_IDX_W'(cnt)]),
    .result  (mac_result)
  );

  a_take_loads: assert property (@(posedge clk) disable iff (rst)
    in_take |=> state == ST_LOAD)
    else $error("accepted word did not start a load");

  a_load_starts_mac: assert property (@(posedge clk) disable iff (rst)
    state == ST_LOAD |=> (state == ST_MAC) && (cnt == '0))
    else $error("multiply sequence did not start at pair zero");

  a_drain_done: assert property (@(posedge clk) disable iff (rst)
    state == ST_DRAIN |=> state == ST_DONE)
    else $error("drain did not finish");

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_DONE)
    else $error("output word appeared outside the done step");

endmodule

`default_nettype wire

FILE: tb/symmetric_fir_lowpass_test.sv
// Self-checking testbench for symmetric_fir_lowpass: drives samples and coefficient
// writes, predicts every filtered word and compares it with the block's output.
// Depends on sfir_pkg and the symmetric_fir_lowpass RTL only.
`timescale 1ns / 100ps

module symmetric_fir_lowpass_test;

  localparam int SETTLE_CYCLES = 16;  // margin beyond the block's latency

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  sfir_pkg::sample_t              sample_in = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  sfir_pkg::sample_t              sample_out;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [sfir_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  sfir_pkg::coef_t                cfg_data = '0;

  // Shadow of the filter state
  sfir_pkg::sample_t fir_line [sfir_pkg::LINE_LEN];
  sfir_pkg::coef_t   coef_shadow [sfir_pkg::NCOEF];
  sfir_pkg::sample_t expected_out [$];

  int  mismatches = 0;
  int  in_gap_pct = 0;
  int  out_stall_pct = 0;
  bit  quiet = 1'b0;

  symmetric_fir_lowpass i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .sample_in  (sample_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sample_out (sample_out),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #4 clk = ~clk;

  // Shift one sample in and form the folded, scaled and saturated sum
  function automatic sfir_pkg::sample_t filter_next(sfir_pkg::sample_t s);
    longint acc;
    longint q;
    for (int k = 0; k < sfir_pkg::LINE_LEN - 1; k++) fir_line[k] = fir_line[k + 1];
    fir_line[sfir_pkg::LINE_LEN - 1] = s;
    acc = longint'(coef_shadow[0]) * longint'(fir_line[sfir_pkg::HALF]);
    for (int k = 1; k <= sfir_pkg::HALF && k < sfir_pkg::NCOEF; k++) begin
      acc += longint'(coef_shadow[k]) *
             (longint'(fir_line[sfir_pkg::HALF + k]) +
              longint'(fir_line[sfir_pkg::HALF - k]));
    end
    q = acc / 65536;  // truncates toward zero
    if (q > longint'(sfir_pkg::SAMPLE_MAX)) q = longint'(sfir_pkg::SAMPLE_MAX);
    if (q < longint'(sfir_pkg::SAMPLE_MIN)) q = longint'(sfir_pkg::SAMPLE_MIN);
    return sfir_pkg::sample_t'(q);
  endfunction

  function automatic sfir_pkg::sample_t rand_sample();
    sfir_pkg::sample_t s;
    case ($urandom_range(0, 9))
      0:       s = sfir_pkg::SAMPLE_MAX;
      1:       s = sfir_pkg::SAMPLE_MIN;
      2, 3:    s = sfir_pkg::sample_t'(int'($urandom_range(0, 4000)) - 2000);
      default: s = sfir_pkg::sample_t'($urandom);
    endcase
    return s;
  endfunction

  // 0 full range, 1 small realistic, 2 corner values, 3 all max, 4 all min
  function automatic sfir_pkg::coef_t rand_coef(int mode);
    sfir_pkg::coef_t c;
    case (mode)
      0: c = sfir_pkg::coef_t'($urandom);
      1: c = sfir_pkg::coef_t'(int'($urandom_range(0, 40000)) - 20000);
      2: begin
        case ($urandom_range(0, 4))
          0:       c = 20'sh7FFFF;
          1:       c = 20'sh80000;
          2:       c = 20'sd0;
          3:       c = -20'sd1;
          default: c = 20'sd1;
        endcase
      end
      3: c = 20'sh7FFFF;
      default: c = 20'sh80000;
    endcase
    return c;
  endfunction

  task automatic send_sample(sfir_pkg::sample_t s);
    if (!quiet && $urandom_range(0, 99) < in_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    sample_in <= s;
    do @(posedge clk); while (in_stall);
    expected_out.push_back(filter_next(s));
  endtask

  // Leaves cfg_valid high; the caller lowers it after its last write
  task automatic write_coef(logic [sfir_pkg::CFG_IDX_W-1:0] idx, sfir_pkg::coef_t data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx < sfir_pkg::NCOEF) coef_shadow[idx[sfir_pkg::COEF_IDX_W-1:0]] = data;
  endtask

  task automatic load_coefs(input sfir_pkg::coef_t vals [sfir_pkg::NCOEF]);
    for (int k = 0; k < sfir_pkg::NCOEF; k++)
      write_coef(sfir_pkg::CFG_IDX_W'(k), vals[k]);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_outputs_done();
    in_valid <= 1'b0;
    while (expected_out.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic note_mismatch(string what, sfir_pkg::sample_t want, sfir_pkg::sample_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: expected %0d, got %0d", $realtime, what, want, got);
  endtask

  // Output side: random stall bursts
  initial begin
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 99) < out_stall_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_out.size() == 0)
        note_mismatch("unexpected output word", '0, sample_out);
      else if (sample_out !== expected_out[0])
        note_mismatch("sample_out", expected_out.pop_front(), sample_out);
      else
        void'(expected_out.pop_front());
    end
  end

  // Reset values: center tap is 1.0, so the output is the input delayed by HALF words
  task automatic test_default_coefs();
    send_sample(sfir_pkg::SAMPLE_MAX);
    send_sample(sfir_pkg::SAMPLE_MIN);
    send_sample(-24'sd1);
    for (int k = 0; k < 5; k++) send_sample('0);
    wait_outputs_done();
  endtask

  // Indexes past the coefficient file must not disturb it
  task automatic test_ignored_index();
    for (int k = sfir_pkg::NCOEF; k < 2 ** sfir_pkg::CFG_IDX_W; k++)
      write_coef(sfir_pkg::CFG_IDX_W'(k), (k % 2) ? 20'sh7FFFF : 20'sh80000);
    cfg_valid <= 1'b0;
    send_sample(24'sd1000);
    send_sample(-24'sd1000);
    send_sample(sfir_pkg::SAMPLE_MAX);
    wait_outputs_done();
  endtask

  task automatic test_saturation();
    sfir_pkg::coef_t vals [sfir_pkg::NCOEF];
    for (int k = 0; k < sfir_pkg::NCOEF; k++) vals[k] = 20'sh7FFFF;
    load_coefs(vals);
    repeat (3) send_sample(sfir_pkg::SAMPLE_MAX);
    send_sample(sfir_pkg::SAMPLE_MIN);
    wait_outputs_done();
    for (int k = 0; k < sfir_pkg::NCOEF; k++) vals[k] = 20'sh80000;
    load_coefs(vals);
    repeat (2) send_sample(sfir_pkg::SAMPLE_MAX);
    repeat (2) send_sample(sfir_pkg::SAMPLE_MIN);
    wait_outputs_done();
  endtask

  // Half weight on the outermost pair only: odd negative sums must round toward zero
  task automatic test_truncation();
    sfir_pkg::coef_t vals [sfir_pkg::NCOEF];
    for (int k = 0; k < sfir_pkg::NCOEF; k++) vals[k] = '0;
    vals[sfir_pkg::NCOEF - 1] = 20'sd32768;
    load_coefs(vals);
    send_sample(-24'sd1);
    send_sample(-24'sd3);
    send_sample(24'sd3);
    send_sample(-24'sd32769);
    wait_outputs_done();
  endtask

  task automatic test_random_streams();
    sfir_pkg::coef_t vals [sfir_pkg::NCOEF];
    int    mode;
    int    pause_at;
    for (int p = 0; p < 7; p++) begin
      mode = (p < 5) ? p : $urandom_range(0, 2);
      for (int k = 0; k < sfir_pkg::NCOEF; k++) vals[k] = rand_coef(mode);
      load_coefs(vals);
      in_gap_pct    = (p == 2) ? 0 : $urandom_range(0, 40);
      out_stall_pct = (p == 3) ? 0 : $urandom_range(0, 40);
      pause_at      = $urandom_range(20, 200);
      for (int n = 0; n < 230; n++) begin
        if (n == pause_at) wait_outputs_done();
        send_sample(rand_sample());
      end
      wait_outputs_done();
    end
  endtask

  // Back-to-back words with no idling on either side
  task automatic test_steady_stream();
    sfir_pkg::coef_t vals [sfir_pkg::NCOEF];
    for (int k = 0; k < sfir_pkg::NCOEF; k++) vals[k] = rand_coef(1);
    load_coefs(vals);
    quiet = 1'b1;
    for (int n = 0; n < 100; n++) send_sample(rand_sample());
    wait_outputs_done();
  endtask

  initial begin
    for (int k = 0; k < sfir_pkg::LINE_LEN; k++) fir_line[k] = '0;
    coef_shadow[0] = sfir_pkg::COEF_CENTER_RST;
    for (int k = 1; k < sfir_pkg::NCOEF; k++) coef_shadow[k] = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_default_coefs();
    test_ignored_index();
    test_saturation();
    test_truncation();
    test_random_streams();
    test_steady_stream();
    if (mismatches == 0 && expected_out.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin
    #8_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
